FILE: sv/jstp_pkg.sv
// ----------------------------------------------------------------------------
// jstp_pkg
// Shared codes, result type and small lexer helpers for the JSON tokenizer.
// ----------------------------------------------------------------------------
package jstp_pkg;

  // Event codes
  localparam logic [3:0] EV_ARR_BEGIN  = 4'd0;
  localparam logic [3:0] EV_ARR_END    = 4'd1;
  localparam logic [3:0] EV_DICT_BEGIN = 4'd2;
  localparam logic [3:0] EV_DICT_END   = 4'd3;
  localparam logic [3:0] EV_INT        = 4'd4;
  localparam logic [3:0] EV_FLOAT_END  = 4'd5;
  localparam logic [3:0] EV_STR_CHAR   = 4'd6;
  localparam logic [3:0] EV_STR_END    = 4'd7;
  localparam logic [3:0] EV_NUM_CHAR   = 4'd8;
  localparam logic [3:0] EV_DOC_END    = 4'd9;

  // Expect-states (bits 2:0) and non-empty flag (bit 3)
  localparam logic [2:0] ST_OBJ       = 3'd0;
  localparam logic [2:0] ST_ARR_ITEM  = 3'd1;
  localparam logic [2:0] ST_ARR_COMMA = 3'd2;
  localparam logic [2:0] ST_KEY       = 3'd3;
  localparam logic [2:0] ST_COLON     = 3'd4;
  localparam logic [2:0] ST_DVAL      = 3'd5;
  localparam logic [2:0] ST_DCOMMA    = 3'd6;

  // Lexer modes
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_STR  = 3'd1;
  localparam logic [2:0] M_ESC  = 3'd2;
  localparam logic [2:0] M_DEC  = 3'd3;
  localparam logic [2:0] M_HEX  = 3'd4;
  localparam logic [2:0] M_FLT  = 3'd5;

  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef struct packed {
    logic [3:0]  ev;
    logic        err;
    logic [7:0]  ch;
    logic [31:0] val;
    logic [4:0]  lvl;
    logic        last;
  } result_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    return is_dec(c) || ((l >= 8'h61) && (l <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    l = c | CASE_BIT;
    if (is_dec(c)) return 4'(c - 8'h30);
    return 4'(l - 8'h57);
  endfunction

  function automatic logic value_ok(input logic [3:0] s, input logic is_str);
    return (s[2:0] == ST_OBJ) || (s[2:0] == ST_ARR_ITEM) || (s[2:0] == ST_DVAL) ||
           (is_str && (s[2:0] == ST_KEY));
  endfunction

  function automatic logic [3:0] after_value(input logic [3:0] s);
    case (s[2:0])
      ST_ARR_ITEM: return {1'b1, ST_ARR_COMMA};
      ST_KEY:      return {1'b1, ST_COLON};
      ST_DVAL:     return {1'b1, ST_DCOMMA};
      default:     return s;
    endcase
  endfunction

  function automatic result_t mk_res(input logic [3:0] ev, input logic err,
                                     input logic [7:0] ch, input logic [31:0] val,
                                     input logic [4:0] lvl);
    result_t r;
    r.ev   = ev;
    r.err  = err;
    r.ch   = ch;
    r.val  = val;
    r.lvl  = lvl;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

FILE: sv/json_stream_tokenizer_parser.sv
// A word's results enter the output queue at the edge that accepts it.
// Throughput: one input word per cycle while in_ready_o is high; each word makes
// 0 to 2 result words, drained one per cycle while out_ready_i is high from a
// 4-entry output queue (set by that queue's port).
// Reset: asynchronous, active low; clears parser control and empties the queue.
// The container stack is not cleared; only entries below the depth are read.
// ----------------------------------------------------------------------------
// json_stream_tokenizer_parser
// Byte-wide streaming JSON lexer and nesting checker with event output.
// ----------------------------------------------------------------------------
module json_stream_tokenizer_parser #(
  parameter int MAX_NESTING = 16,
  parameter int TOKEN_CHARS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         input_byte_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         event_res_o,
  output logic               error_flag_o,
  output logic [7:0]         char_out_o,
  output logic signed [31:0] int_value_o,
  output logic [4:0]         nesting_level_o,
  output logic               last_of_run_o
);

  localparam int SPW = $clog2(MAX_NESTING + 1);
  localparam int IXW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int TLW = $clog2(TOKEN_CHARS);
  localparam logic [TLW-1:0] TLEN_MAX = TLW'(TOKEN_CHARS - 1);
  localparam logic [SPW-1:0] SP_MAX   = SPW'(MAX_NESTING);

  // Parser state. top_q caches the expect-state of the innermost open level
  // (the top level when the depth is zero); saved_q holds the outer levels.
  logic [3:0]     top_q, top_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [2:0]     mode_q, mode_d;
  logic [TLW-1:0] tlen_q, tlen_d;
  logic [7:0]     prev_q, prev_d;
  logic           exps_q, exps_d;
  logic           neg_q, neg_d;
  logic [31:0]    acc_q, acc_d;
  logic           fail_q, fail_d;

  logic [3:0]     saved_q [MAX_NESTING];
  logic           sv_we;
  logic [3:0]     sv_wdata;
  logic [SPW-1:0] sp_m1;
  logic [3:0]     sv_rdata;

  jstp_pkg::result_t res_d [2];
  logic [1:0]        n_res;

  logic accept;

  assign sp_m1    = sp_q - 1'b1;
  assign sv_rdata = saved_q[sp_m1[IXW-1:0]];
  assign accept   = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // One-word step: mode handling, optional number finish, then token start
  // or end-of-text check. Results go into res_d in order.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [7:0]  c;
    logic        do_fin, do_ts, do_eoi, ok;
    logic [SPW+4:0] spx;
    c      = input_byte_i;
    do_fin = 1'b0;
    do_ts  = 1'b0;
    do_eoi = 1'b0;
    ok     = 1'b0;
    top_d  = top_q;
    sp_d   = sp_q;
    mode_d = mode_q;
    tlen_d = tlen_q;
    prev_d = prev_q;
    exps_d = exps_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    fail_d = fail_q;
    sv_we    = 1'b0;
    sv_wdata = top_q;
    n_res    = 2'd0;
    spx      = {5'd0, sp_q};
    res_d[0] = jstp_pkg::mk_res(jstp_pkg::EV_DOC_END, 1'b1, 8'd0, 32'd0, spx[4:0]);
    res_d[1] = res_d[0];

    if (fail_q) begin
      n_res = 2'd1;
    end else if (end_of_input_i) begin
      do_fin = (mode_q >= jstp_pkg::M_DEC);
      do_eoi = 1'b1;
    end else begin
      case (mode_q)
        jstp_pkg::M_STR: begin
          if (c == jstp_pkg::CH_BSLASH) begin
            mode_d = jstp_pkg::M_ESC;
          end else if (c == jstp_pkg::CH_QUOTE) begin
            mode_d = jstp_pkg::M_IDLE;
            res_d[0] = jstp_pkg::mk_res(jstp_pkg::EV_STR_END, 1'b0, 8'd0, 32'd0, spx[4:0]);
            n_res = 2'd1;
            top_d = jstp_pkg::after_value(top_q);
          end else if (tlen_q >= TLEN_MAX) begin
            fail_d = 1'b1;
            n_res  = 2'd1;
          end else begin
            tlen_d = tlen_q + 1'b1;
            res_d[0] = jstp_pkg::mk_res(jstp_pkg::EV_STR_CHAR, 1'b0, c, 32'd0, spx[4:0]);
            n_res = 2'd1;
          end
        end
        jstp_pkg::M_ESC: begin
          mode_d = jstp_pkg::M_STR;
          if (tlen_q >= TLEN_MAX) begin
            fail_d = 1'b1;
            n_res  = 2'd1;
          end else begin
            tlen_d = tlen_q + 1'b1;
            res_d[0] = jstp_pkg::mk_res(jstp_pkg::EV_STR_CHAR, 1'b0, c, 32'd0, spx[4:0]);
            n_res = 2'd1;
          end
        end
        jstp_pkg::M_DEC, jstp_pkg::M_HEX, jstp_pkg::M_FLT: begin
          // Classify the byte as part of the number or as its terminator.
          ok = 1'b0;
          if (mode_q == jstp_pkg::M_DEC) begin
            if (tlen_q == TLW'(1) && prev_q == 8'h30 &&
                (c | jstp_pkg::CASE_BIT) == 8'h78) begin
              mode_d = jstp_pkg::M_HEX;
              ok = 1'b1;
            end else if (c == 8'h2E) begin
              mode_d = jstp_pkg::M_FLT;
              exps_d = 1'b0;
              ok = 1'b1;
            end else if (jstp_pkg::is_dec(c)) begin
              acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, 4'(c - 8'h30)};
              ok = 1'b1;
            end
          end else if (mode_q == jstp_pkg::M_HEX) begin
            if (jstp_pkg::is_hex(c)) begin
              acc_d = {acc_q[27:0], jstp_pkg::hex_val(c)};
              ok = 1'b1;
            end
          end else begin
            if (jstp_pkg::is_dec(c)) begin
              ok = 1'b1;
            end else if ((c | jstp_pkg::CASE_BIT) == 8'h65) begin
              if (exps_q) begin
                fail_d = 1'b1;
                n_res  = 2'd1;
              end else begin
                exps_d = 1'b1;
                ok = 1'b1;
              end
            end else if (c == 8'h2B || c == 8'h2D) begin
              if ((prev_q | jstp_pkg::CASE_BIT) == 8'h65) begin
                ok = 1'b1;
              end else begin
                fail_d = 1'b1;
                n_res  = 2'd1;
              end
            end
          end
          if (ok) begin
            if (tlen_q >= TLEN_MAX) begin
              fail_d = 1'b1;
              n_res  = 2'd1;
            end else begin
              tlen_d = tlen_q + 1'b1;
              prev_d = c;
              res_d[0] = jstp_pkg::mk_res(jstp_pkg::EV_NUM_CHAR, 1'b0, c, 32'd0, spx[4:0]);
              n_res = 2'd1;
            end
          end else if (!fail_d) begin
            do_fin = 1'b1;
            do_ts  = 1'b1;
          end
        end
        default: begin
          mode_d = jstp_pkg::M_IDLE;
          do_ts  = 1'b1;
        end
      endcase
    end

    // Finish a pending number: check its last character, emit its event.
    if (do_fin) begin
      ok = (mode_q == jstp_pkg::M_HEX) ? jstp_pkg::is_hex(prev_q) : jstp_pkg::is_dec(prev_q);
      mode_d = jstp_pkg::M_IDLE;
      if (!ok) begin
        fail_d = 1'b1;
        n_res  = 2'd1;
        do_ts  = 1'b0;
        do_eoi = 1'b0;
      end else begin
        if (mode_q == jstp_pkg::M_FLT) begin
          res_d[0] = jstp_pkg::mk_res(jstp_pkg::EV_FLOAT_END, 1'b0, 8'd0, 32'd0, spx[4:0]);
        end else begin
          res_d[0] = jstp_pkg::mk_res(jstp_pkg::EV_INT, 1'b0, 8'd0,
                                      neg_q ? (32'd0 - acc_q) : acc_q, spx[4:0]);
        end
        n_res = 2'd1;
        top_d = jstp_pkg::after_value(top_q);
      end
    end

    // Start a token with this byte.
    if (do_ts) begin
      ok = 1'b1;
      case (c)
        8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin
        end
        8'h5B, 8'h7B: begin
          if (!jstp_pkg::value_ok(top_d, 1'b0) || sp_q >= SP_MAX) begin
            ok = 1'b0;
          end else begin
            sv_we    = 1'b1;
            sv_wdata = top_d;
            top_d    = (c == 8'h7B) ? {1'b0, jstp_pkg::ST_KEY} : {1'b0, jstp_pkg::ST_ARR_ITEM};
            sp_d     = sp_q + 1'b1;
            spx      = {5'd0, sp_d};
            res_d[n_res[0]] = jstp_pkg::mk_res((c == 8'h7B) ? jstp_pkg::EV_DICT_BEGIN :
                                               jstp_pkg::EV_ARR_BEGIN, 1'b0, 8'd0, 32'd0,
                                               spx[4:0]);
            n_res = n_res + 2'd1;
          end
        end
        8'h5D, 8'h7D: begin
          if (sp_q == '0) begin
            ok = 1'b0;
          end else if (c == 8'h7D) begin
            ok = (top_d[2:0] == jstp_pkg::ST_DCOMMA) ||
                 (top_d[2:0] == jstp_pkg::ST_KEY && !top_d[3]);
          end else begin
            ok = (top_d[2:0] == jstp_pkg::ST_ARR_COMMA) ||
                 (top_d[2:0] == jstp_pkg::ST_ARR_ITEM && !top_d[3]);
          end
          if (ok) begin
            sp_d  = sp_m1;
            spx   = {5'd0, sp_d};
            top_d = jstp_pkg::after_value(sv_rdata);
            res_d[n_res[0]] = jstp_pkg::mk_res((c == 8'h7D) ? jstp_pkg::EV_DICT_END :
                                               jstp_pkg::EV_ARR_END, 1'b0, 8'd0, 32'd0,
                                               spx[4:0]);
            n_res = n_res + 2'd1;
          end
        end
        8'h2C: begin
          if (top_d[2:0] == jstp_pkg::ST_ARR_COMMA) begin
            top_d = {top_d[3], jstp_pkg::ST_ARR_ITEM};
          end else if (top_d[2:0] == jstp_pkg::ST_DCOMMA) begin
            top_d = {top_d[3], jstp_pkg::ST_KEY};
          end else begin
            ok = 1'b0;
          end
        end
        8'h3A: begin
          if (top_d[2:0] == jstp_pkg::ST_COLON) begin
            top_d = {top_d[3], jstp_pkg::ST_DVAL};
          end else begin
            ok = 1'b0;
          end
        end
        jstp_pkg::CH_QUOTE: begin
          if (jstp_pkg::value_ok(top_d, 1'b1)) begin
            mode_d = jstp_pkg::M_STR;
            tlen_d = '0;
          end else begin
            ok = 1'b0;
          end
        end
        default: begin
          if ((c == 8'h2B || c == 8'h2D || jstp_pkg::is_dec(c)) &&
              jstp_pkg::value_ok(top_d, 1'b0)) begin
            mode_d = jstp_pkg::M_DEC;
            exps_d = 1'b0;
            neg_d  = (c == 8'h2D);
            acc_d  = jstp_pkg::is_dec(c) ? {28'd0, 4'(c - 8'h30)} : 32'd0;
            tlen_d = TLW'(1);
            prev_d = c;
            res_d[n_res[0]] = jstp_pkg::mk_res(jstp_pkg::EV_NUM_CHAR, 1'b0, c, 32'd0,
                                               spx[4:0]);
            n_res = n_res + 2'd1;
          end else begin
            ok = 1'b0;
          end
        end
      endcase
      if (!ok) begin
        fail_d = 1'b1;
        res_d[n_res[0]] = jstp_pkg::mk_res(jstp_pkg::EV_DOC_END, 1'b1, 8'd0, 32'd0, spx[4:0]);
        n_res = n_res + 2'd1;
      end
    end

    // End of text: open string or container is an error.
    if (do_eoi) begin
      if (mode_d == jstp_pkg::M_STR || mode_d == jstp_pkg::M_ESC || sp_q != '0) begin
        fail_d = 1'b1;
        res_d[n_res[0]] = jstp_pkg::mk_res(jstp_pkg::EV_DOC_END, 1'b1, 8'd0, 32'd0, spx[4:0]);
      end else begin
        res_d[n_res[0]] = jstp_pkg::mk_res(jstp_pkg::EV_DOC_END, 1'b0, 8'd0, 32'd0, spx[4:0]);
      end
      n_res = n_res + 2'd1;
    end

    // Mark the last result of this word.
    if (n_res == 2'd2) begin
      res_d[1].last = 1'b1;
    end else if (n_res == 2'd1) begin
      res_d[0].last = 1'b1;
    end
  end

  // Advance the parser state on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= {1'b0, jstp_pkg::ST_OBJ};
      sp_q   <= '0;
      mode_q <= jstp_pkg::M_IDLE;
      tlen_q <= '0;
      prev_q <= '0;
      exps_q <= 1'b0;
      neg_q  <= 1'b0;
      acc_q  <= '0;
      fail_q <= 1'b0;
    end else if (accept) begin
      top_q  <= top_d;
      sp_q   <= sp_d;
      mode_q <= mode_d;
      tlen_q <= tlen_d;
      prev_q <= prev_d;
      exps_q <= exps_d;
      neg_q  <= neg_d;
      acc_q  <= acc_d;
      fail_q <= fail_d;
    end
  end

  // Save the enclosing level's state on every container open.
  always_ff @(posedge clk_i) begin
    if (accept && sv_we) begin
      saved_q[sp_q[IXW-1:0]] <= sv_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: four entries; take a word only with room for two results.
  // --------------------------------------------------------------------------
  jstp_pkg::result_t fifo_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;
  logic [2:0] push_n;

  assign in_ready_o  = (cnt_q <= 3'd2);
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = accept ? {1'b0, n_res} : 3'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_n[1:0];
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_q + push_n - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && n_res != 2'd0) begin
      fifo_q[wr_q] <= res_d[0];
    end
    if (accept && n_res == 2'd2) begin
      fifo_q[wr_q + 2'd1] <= res_d[1];
    end
  end

  jstp_pkg::result_t head;
  assign head            = fifo_q[rd_q];
  assign event_res_o     = head.ev;
  assign error_flag_o    = head.err;
  assign char_out_o      = head.ch;
  assign int_value_o     = head.val;
  assign nesting_level_o = head.lvl;
  assign last_of_run_o   = head.last;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("output queue overfilled");

  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_MAX) else $error("nesting depth beyond limit");

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fail_q |=> fail_q) else $error("error flag cleared");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_flag_o) |->
      (event_res_o == jstp_pkg::EV_DOC_END && char_out_o == 8'd0 && int_value_o == 32'sd0))
    else $error("malformed error result");
`endif

endmodule
